/* rtl/ewbe_pkg.sv */
package ewbe_pkg;

   localparam int NUM_SLOTS = 10;

   typedef struct packed {
      logic [NUM_SLOTS-1:0]      valid;
      logic [NUM_SLOTS-1:0][7:0] bytes;
   } entry_type;

endpackage

/* rtl/ewbe_front.sv */
module ewbe_front import ewbe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // word_value[35:0], zeros
   input  logic [0:0]  req_tuser,   // cmd
   output logic        enq_valid,
   input  logic        enq_ready,
   output entry_type   enq_data
);

   typedef enum logic [1:0] {
      ESC_NONE = 2'd0,
      ESC_CR   = 2'd1,
      ESC_DEL  = 2'd2
   } esc_type;

   typedef struct packed {
      logic       pre_v;
      logic [7:0] pre_b;
      logic       main_v;
      logic [7:0] main_b;
      esc_type    pend;
   } char_res_type;

   localparam logic [6:0] CH_BEL    = 7'o007;
   localparam logic [6:0] CH_LF     = 7'o012;
   localparam logic [6:0] CH_CR     = 7'o015;
   localparam logic [6:0] CH_DEL    = 7'o177;
   localparam logic [6:0] CH_DELMAX = 7'o155;
   localparam logic [7:0] B_LF      = 8'o012;
   localparam logic [7:0] B_CR      = 8'o015;
   localparam logic [7:0] B_DEL     = 8'o177;
   localparam logic [7:0] B_DEL_LF  = 8'o215;
   localparam logic [7:0] B_DEL_CR  = 8'o212;
   localparam logic [7:0] B_DEL_DEL = 8'o207;
   localparam logic [7:0] B_CR_ESC  = 8'o356;
   localparam logic [7:0] B_DEL_ESC = 8'o357;
   localparam logic [3:0] B_BIN_HI  = 4'hF;

   function automatic char_res_type xlate(input esc_type pend, input logic [6:0] c);
      char_res_type r;
      logic         done;
      r    = '0;
      done = 1'b0;
      r.pend = ESC_NONE;
      case (pend)
         ESC_CR: begin
            if (c == CH_LF) begin
               r.main_v = 1'b1;
               r.main_b = B_LF;
               done     = 1'b1;
            end else begin
               r.pre_v = 1'b1;
               r.pre_b = B_CR_ESC;
            end
         end
         ESC_DEL: begin
            done = 1'b1;
            r.main_v = 1'b1;
            if (c == CH_BEL) begin
               r.main_b = B_DEL;
            end else if (c == CH_LF) begin
               r.main_b = B_DEL_LF;
            end else if (c == CH_CR) begin
               r.main_b = B_DEL_CR;
            end else if (c == CH_DEL) begin
               r.main_b = B_DEL_DEL;
            end else if (c <= CH_DELMAX) begin
               r.main_b = {1'b1, c};
            end else begin
               done     = 1'b0;
               r.main_v = 1'b0;
               r.pre_v  = 1'b1;
               r.pre_b  = B_DEL_ESC;
            end
         end
         default: begin
         end
      endcase
      if (!done) begin
         if (c == CH_CR) begin
            r.pend = ESC_CR;
         end else if (c == CH_DEL) begin
            r.pend = ESC_DEL;
         end else if (c == CH_LF) begin
            r.main_v = 1'b1;
            r.main_b = B_CR;
         end else begin
            r.main_v = 1'b1;
            r.main_b = {1'b0, c};
         end
      end
      return r;
   endfunction

   esc_type      pend_ff, pend_in;
   esc_type      p;
   char_res_type cr;
   entry_type    entry;
   logic [35:0]  word;
   logic         cmd;

   assign word = req_tdata[35:0];
   assign cmd  = req_tuser[0];

   always_comb begin
      entry   = '0;
      p       = pend_ff;
      cr      = '0;
      pend_in = ESC_NONE;
      if (cmd || word[0]) begin
         if (pend_ff == ESC_CR) begin
            entry.valid[0] = 1'b1;
            entry.bytes[0] = B_CR_ESC;
         end else if (pend_ff == ESC_DEL) begin
            entry.valid[0] = 1'b1;
            entry.bytes[0] = B_DEL_ESC;
         end
         if (!cmd) begin
            entry.valid[5:1] = '1;
            entry.bytes[1]   = {B_BIN_HI, word[35:32]};
            entry.bytes[2]   = word[31:24];
            entry.bytes[3]   = word[23:16];
            entry.bytes[4]   = word[15:8];
            entry.bytes[5]   = word[7:0];
         end
      end else begin
         for (int i = 0; i < 5; i++) begin
            cr = xlate(p, word[35-7*i -: 7]);
            entry.valid[2*i]   = cr.pre_v;
            entry.bytes[2*i]   = cr.pre_b;
            entry.valid[2*i+1] = cr.main_v;
            entry.bytes[2*i+1] = cr.main_b;
            p = cr.pend;
         end
         pend_in = p;
      end
   end

   assign req_tready = enq_ready;
   assign enq_valid  = req_tvalid && (|entry.valid);
   assign enq_data   = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= ESC_NONE;
      end else if (req_tvalid && req_tready) begin
         pend_ff <= pend_in;
      end
   end

endmodule

/* rtl/ewbe_fifo.sv */
module ewbe_fifo import ewbe_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      enq_valid,
   output logic      enq_ready,
   input  entry_type enq_data,
   output logic      head_valid,
   input  logic      head_pop,
   output entry_type head_data
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   entry_type         store_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]     count_ff;
   logic              push, pop;

   assign enq_ready  = (count_ff != FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_data  = store_ff[rd_ptr_ff];
   assign push       = enq_valid && enq_ready;
   assign pop        = head_pop && head_valid;

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= enq_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("Queue count exceeds its depth.");

   a_push_full : assert property (@(posedge clock) disable iff (reset)
      (count_ff == FULL_CNT && !pop) |=> count_ff == FULL_CNT)
      else $error("A full queue lost an entry without a pop.");

   a_stored_nonempty : assert property (@(posedge clock) disable iff (reset)
      push |-> (|enq_data.valid))
      else $error("An entry without bytes was queued.");

endmodule

/* rtl/ewbe_back.sv */
module ewbe_back import ewbe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   output logic       head_pop,
   input  entry_type  head_data,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic       rsp_tlast    // last
);

   logic [NUM_SLOTS-1:0] done_ff, done_in;
   logic [NUM_SLOTS-1:0] rem, sel;
   logic                 out_ok, fire, last;
   logic [7:0]           sel_byte;
   logic                 valid_ff;
   logic [7:0]           byte_ff;
   logic                 last_ff;

   assign rem    = head_data.valid & ~done_ff;
   assign sel    = rem & (~rem + 1'b1);
   assign last   = ((rem & ~sel) == '0);
   assign out_ok = !valid_ff || rsp_tready;
   assign fire   = head_valid && out_ok;
   assign head_pop = fire && last;

   always_comb begin
      sel_byte = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         sel_byte = sel_byte | (head_data.bytes[i] & {8{sel[i]}});
      end
   end

   always_comb begin
      done_in = done_ff;
      if (head_pop) begin
         done_in = '0;
      end else if (fire) begin
         done_in = done_ff | sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
         if (out_ok) begin
            valid_ff <= fire;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         byte_ff <= sel_byte;
         last_ff <= last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;

   a_sel_onehot : assert property (@(posedge clock) disable iff (reset)
      fire |-> $onehot(sel))
      else $error("No single slot chosen for an issued beat.");

   a_done_subset : assert property (@(posedge clock) disable iff (reset)
      head_valid |-> ((done_ff & ~head_data.valid) == '0))
      else $error("Sent mask marks a slot that holds no byte.");

   a_pop_clears : assert property (@(posedge clock) disable iff (reset)
      head_pop |=> done_ff == '0)
      else $error("Sent mask not cleared after the final beat of an item.");

endmodule

/* rtl/evacuate_word_byte_encoder.sv */
// Each beat taken at the input is classified at once and queued if it yields bytes; its first byte is
// registered at the output once it is at the head of the queue and the output register can take it.
// The output sequencer sends one byte per cycle while rsp_tready allows it; an item yields
// 1 to 6 bytes, typically 5 for a text word, 5 or 6 for a binary word.
// A flush with nothing held yields no beat and is not queued.
// Synchronous active-high reset empties the queue and output register and clears escapes.
module evacuate_word_byte_encoder import ewbe_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // word_value[35:0], zeros
   input  logic [0:0]  req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   output logic        rsp_tlast    // last
);

   entry_type enq_data, head_data;
   logic      enq_valid, enq_ready, head_valid, head_pop;

   ewbe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .enq_valid  (enq_valid),
      .enq_ready  (enq_ready),
      .enq_data   (enq_data)
   );

   ewbe_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .enq_valid  (enq_valid),
      .enq_ready  (enq_ready),
      .enq_data   (enq_data),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .head_data  (head_data)
   );

   ewbe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .head_data  (head_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* sim/ewbe_test_pkg.sv */
package ewbe_test_pkg;

   localparam logic CMD_ENCODE = 1'b0;
   localparam logic CMD_FLUSH  = 1'b1;

   localparam logic [6:0] CH_NUL         = 7'o000;
   localparam logic [6:0] CH_BEL         = 7'o007;
   localparam logic [6:0] CH_LF          = 7'o012;
   localparam logic [6:0] CH_CR          = 7'o015;
   localparam logic [6:0] CH_MERGE_TOP   = 7'o155;
   localparam logic [6:0] CH_ABOVE_MERGE = 7'o156;
   localparam logic [6:0] CH_DEL         = 7'o177;

endpackage

/* sim/ewbe_stream_checker.sv */
module ewbe_stream_checker
   import ewbe_test_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic [0:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        rsp_tlast,
   output int          mismatch_count,
   output int          bytes_awaited
);

   localparam logic [7:0] HELD_CR_CODE  = 8'o356;
   localparam logic [7:0] HELD_DEL_CODE = 8'o357;
   localparam logic [7:0] BINARY_LEAD   = 8'o360;
   localparam logic [7:0] CR_LF_CODE    = 8'o012;
   localparam logic [7:0] LONE_LF_CODE  = 8'o015;
   localparam logic [7:0] DEL_BEL_CODE  = 8'o177;
   localparam logic [7:0] DEL_LF_CODE   = 8'o215;
   localparam logic [7:0] DEL_CR_CODE   = 8'o212;
   localparam logic [7:0] DEL_DEL_CODE  = 8'o207;
   localparam logic [7:0] DEL_MERGE_BIT = 8'o200;

   typedef enum logic [1:0] {
      HOLD_NONE = 2'd0,
      HOLD_CR   = 2'd1,
      HOLD_DEL  = 2'd2
   } escape_t;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } out_byte_t;

   out_byte_t expected_bytes[$];
   escape_t   held_escape = HOLD_NONE;
   int        mismatches  = 0;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %0s", $realtime, what);
      mismatches++;
   endtask

   function automatic void queue_byte(input logic [7:0] code);
      expected_bytes.push_back('{code: code, last: 1'b0});
   endfunction

   function automatic void flush_escape();
      if (held_escape == HOLD_CR) begin
         queue_byte(HELD_CR_CODE);
      end else if (held_escape == HOLD_DEL) begin
         queue_byte(HELD_DEL_CODE);
      end
      held_escape = HOLD_NONE;
   endfunction

   function automatic void translate_char(input logic [6:0] c);
      case (held_escape)
         HOLD_CR: begin
            held_escape = HOLD_NONE;
            if (c == CH_LF) begin
               queue_byte(CR_LF_CODE);
               return;
            end
            queue_byte(HELD_CR_CODE);
         end
         HOLD_DEL: begin
            held_escape = HOLD_NONE;
            if (c == CH_BEL) begin
               queue_byte(DEL_BEL_CODE);
               return;
            end else if (c == CH_LF) begin
               queue_byte(DEL_LF_CODE);
               return;
            end else if (c == CH_CR) begin
               queue_byte(DEL_CR_CODE);
               return;
            end else if (c == CH_DEL) begin
               queue_byte(DEL_DEL_CODE);
               return;
            end else if (c <= CH_MERGE_TOP) begin
               queue_byte({1'b0, c} + DEL_MERGE_BIT);
               return;
            end
            queue_byte(HELD_DEL_CODE);
         end
         default: begin
            held_escape = HOLD_NONE;
         end
      endcase
      if (c == CH_CR) begin
         held_escape = HOLD_CR;
      end else if (c == CH_DEL) begin
         held_escape = HOLD_DEL;
      end else if (c == CH_LF) begin
         queue_byte(LONE_LF_CODE);
      end else begin
         queue_byte({1'b0, c});
      end
   endfunction

   function automatic void encode_beat(input logic cmd, input logic [35:0] w);
      int        bytes_at_start;
      out_byte_t tail;
      bytes_at_start = expected_bytes.size();
      if (cmd == CMD_FLUSH) begin
         flush_escape();
      end else if (w[0]) begin
         flush_escape();
         queue_byte(BINARY_LEAD | {4'b0, w[35:32]});
         queue_byte(w[31:24]);
         queue_byte(w[23:16]);
         queue_byte(w[15:8]);
         queue_byte(w[7:0]);
      end else begin
         for (int i = 0; i < 5; i++) begin
            translate_char(w[35 - 7 * i -: 7]);
         end
      end
      if (expected_bytes.size() > bytes_at_start) begin
         tail = expected_bytes.pop_back();
         tail.last = 1'b1;
         expected_bytes.push_back(tail);
      end
   endfunction

   always @(posedge clock) begin
      out_byte_t want;
      if (reset) begin
         expected_bytes.delete();
         held_escape = HOLD_NONE;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("beat %h last %b with nothing expected",
                                         rsp_tdata, rsp_tlast));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_tdata !== want.code) begin
                  report_mismatch($sformatf("byte %h, expected %h", rsp_tdata, want.code));
               end
               if (rsp_tlast !== want.last) begin
                  report_mismatch($sformatf("last %b, expected %b on byte %h",
                                            rsp_tlast, want.last, want.code));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            encode_beat(req_tuser[0], req_tdata[35:0]);
         end
      end
      mismatch_count <= mismatches;
      bytes_awaited  <= expected_bytes.size();
   end

endmodule

/* sim/evacuate_word_byte_encoder_test.sv */
module evacuate_word_byte_encoder_test;
   import ewbe_test_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int HOLD_CYCLES     = 300;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int DRAIN_CYCLES    = 30;
   localparam int SEND_IDLE[4]    = '{0, 88, 0, 9};
   localparam int RECV_STALL[4]   = '{0, 0, 88, 9};

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;
   logic [0:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;

   int mismatch_count;
   int bytes_awaited;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit hold_request   = 1'b0;
   bit hold_taken     = 1'b0;
   int hold_left      = 0;
   int cycles         = 0;

   evacuate_word_byte_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   ewbe_stream_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .bytes_awaited  (bytes_awaited)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // The long hold-off lets the encoder fill its queue while beats keep being offered.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_request && !hold_taken) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         hold_taken <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic logic [35:0] text_word(input logic [6:0] c0, input logic [6:0] c1,
                                             input logic [6:0] c2, input logic [6:0] c3,
                                             input logic [6:0] c4);
      return {c0, c1, c2, c3, c4, 1'b0};
   endfunction

   function automatic logic [6:0] pick_char();
      case ($urandom_range(9))
         0: return CH_CR;
         1: return CH_LF;
         2: return CH_DEL;
         3: return CH_BEL;
         4: return CH_MERGE_TOP;
         5: return CH_ABOVE_MERGE;
         default: return 7'($urandom_range(127));
      endcase
   endfunction

   task automatic send_beat(input logic cmd, input logic [35:0] w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, w};
      req_tuser  <= cmd;
      do begin
         @(posedge clock);
      end while (!req_tready);
   endtask

   task automatic send_random_beat();
      int          pick;
      logic [35:0] w;
      pick = $urandom_range(99);
      w    = {4'($urandom_range(15)), 32'($urandom())};
      if (pick < 8) begin
         send_beat(CMD_FLUSH, w);
      end else if (pick < 30) begin
         send_beat(CMD_ENCODE, w | 36'h1);
      end else begin
         send_beat(CMD_ENCODE, text_word(pick_char(), pick_char(), pick_char(),
                                         pick_char(), pick_char()));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_beat(CMD_FLUSH, 36'h0);
      send_beat(CMD_ENCODE, 36'h0_0000_0001);
      send_beat(CMD_ENCODE, 36'hF_FFFF_FFFF);
      send_beat(CMD_ENCODE, text_word(CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL));
      send_beat(CMD_ENCODE, text_word(CH_DEL, CH_DEL, CH_DEL, CH_DEL, CH_DEL));
      send_beat(CMD_FLUSH, 36'hF_FFFF_FFFE);
      send_beat(CMD_ENCODE, text_word(CH_LF, CH_CR, CH_LF, CH_CR, 7'h41));
      send_beat(CMD_ENCODE, text_word(CH_DEL, CH_BEL, CH_DEL, CH_LF, CH_CR));
      send_beat(CMD_FLUSH, 36'h0);
      send_beat(CMD_ENCODE, text_word(CH_DEL, CH_CR, CH_DEL, CH_MERGE_TOP, CH_DEL));
      send_beat(CMD_ENCODE, text_word(CH_ABOVE_MERGE, 7'h78, CH_CR, CH_CR, CH_CR));
      send_beat(CMD_ENCODE, 36'h8_1234_5679);
      send_beat(CMD_ENCODE, text_word(7'h61, 7'h62, 7'h63, 7'h64, CH_DEL));
      send_beat(CMD_ENCODE, 36'h7_EDCB_A987);
      send_beat(CMD_ENCODE, text_word(7'h71, 7'h71, 7'h71, 7'h71, CH_CR));
      send_beat(CMD_ENCODE, text_word(CH_LF, CH_DEL, CH_DEL, 7'h7E, 7'h20));
      send_beat(CMD_ENCODE, text_word(CH_CR, CH_NUL, CH_DEL, CH_ABOVE_MERGE, CH_LF));
      send_beat(CMD_FLUSH, 36'h0);

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = SEND_IDLE[phase];
         recv_stall_pct = RECV_STALL[phase];
         if (phase == 0) begin
            hold_request <= 1'b1;
         end
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            send_random_beat();
         end
      end
      req_tvalid <= 1'b0;
      recv_stall_pct = 0;

      @(posedge clock);
      while (bytes_awaited != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && bytes_awaited == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/ewbe_pkg.sv
rtl/ewbe_front.sv
rtl/ewbe_fifo.sv
rtl/ewbe_back.sv
rtl/evacuate_word_byte_encoder.sv
sim/ewbe_test_pkg.sv
sim/ewbe_stream_checker.sv
sim/evacuate_word_byte_encoder_test.sv
